@@ hw/rtl/parameter_block_store_core_assert.svh @@
// Assertion macros shared by the parameter store RTL.
`ifndef PARAMETER_BLOCK_STORE_CORE_ASSERT_SVH
`define PARAMETER_BLOCK_STORE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PBS_ASSERT(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error("pbs assertion failed");
`define PBS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("pbs assertion failed");
`define PBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("pbs assertion failed");
`else
`define PBS_ASSERT(lbl, clk, rstn, expr)
`define PBS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define PBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ hw/rtl/pbs_pkg.sv @@
`default_nettype none
package pbs_pkg;
	localparam int SLOTS = 64;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int FREE_W = 8;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_ERASE = 2'd2;

	localparam logic [1:0] STAT_DONE      = 2'd0;
	localparam logic [1:0] STAT_UNCHANGED = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;
	localparam logic [1:0] STAT_NOTFOUND  = 2'd3;

	typedef struct packed {
		logic [63:0] bytes;
		logic [7:0]  typ;
		logic [7:0]  chunk;
		logic [31:0] id;
	} slot_t;

	typedef struct packed {
		logic hit;
		logic id_hit;
		logic same;
	} match_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_FIN  = 3'b100
	} state_t;
endpackage
`default_nettype wire

@@ hw/rtl/pbs_slot_mem.sv @@
`default_nettype none
module pbs_slot_mem
	import pbs_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  wire slot_t            wr_data,
	input  wire logic             rd_en,
	input  wire logic [IDX_W-1:0] rd_addr,
	output slot_t                 rd_data
);
	slot_t mem [SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/pbs_match.sv @@
`default_nettype none
module pbs_match
	import pbs_pkg::*;
(
	input  wire slot_t       slot,
	input  wire logic        used,
	input  wire logic [31:0] id,
	input  wire logic [7:0]  chunk,
	input  wire logic [7:0]  typ,
	input  wire logic [63:0] bytes,
	output match_t           res
);
	always_comb begin
		res.id_hit = used && (slot.id == id);
		res.hit    = res.id_hit && (slot.chunk == chunk);
		res.same   = (slot.typ == typ) && (slot.bytes == bytes);
	end
endmodule
`default_nettype wire

@@ hw/rtl/parameter_block_store_core.sv @@
// Parameter store: a table of SLOTS slots, each holding a 32-bit id, a chunk
// number, a type code and 8 data bytes. Every operation (write, read, erase)
// walks the whole table one slot per cycle through the single read port of
// the slot memory and one shared compare unit, then finishes in a finish
// state that waits while the output register still holds an untaken result.
// A new item is accepted only after the last one has finished; s_tready is
// low meanwhile. A result waiting in the output register does not block the
// next accept, only the finish of the next item. Slot occupancy lives in
// flip-flops cleared by reset, so no clearing pass is run.
`default_nettype none
module parameter_block_store_core
	import pbs_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [111:0] s_tdata,  // param_id, chunk_index, type_code, chunk_data
	input  wire logic [1:0]   s_tuser,  // kind
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [71:0]       m_tdata,  // read_data, free_slots
	output logic [1:0]        m_tuser   // status
);
`include "parameter_block_store_core_assert.svh"

	state_t state_q;

	logic [1:0]  kind_q;
	logic [31:0] id_q;
	logic [7:0]  chunk_q;
	logic [7:0]  type_q;
	logic [63:0] data_q;

	logic [IDX_W-1:0] cnt_q;
	logic             issue_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;

	logic             found_q;
	logic             same_q;
	logic [IDX_W-1:0] old_q;
	logic             free_found_q;
	logic [IDX_W-1:0] dst_q;
	logic [63:0]      rdata_q;

	logic [SLOTS-1:0] used_q;
	logic [CNT_W-1:0] free_q;

	logic        m_tvalid_q;
	logic [71:0] m_tdata_q;
	logic [1:0]  m_tuser_q;

	slot_t  rd_slot;
	slot_t  wr_slot;
	match_t mres;

	logic             accept;
	logic             last_s1;
	logic             fin_go;
	logic             commit;
	logic [1:0]       fin_status;
	logic [63:0]      fin_rdata;
	logic [CNT_W-1:0] free_after;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign last_s1  = vld_s1 && (idx_s1 == IDX_W'(SLOTS - 1));
	assign fin_go   = (state_q == S_FIN) && (!m_tvalid_q || m_tready);

	assign wr_slot.id    = id_q;
	assign wr_slot.chunk = chunk_q;
	assign wr_slot.typ   = type_q;
	assign wr_slot.bytes = data_q;

	pbs_slot_mem u_mem (
		.clk     (clk),
		.wr_en   (commit),
		.wr_addr (dst_q),
		.wr_data (wr_slot),
		.rd_en   (issue_q),
		.rd_addr (cnt_q),
		.rd_data (rd_slot)
	);

	pbs_match u_match (
		.slot  (rd_slot),
		.used  (used_q[idx_s1]),
		.id    (id_q),
		.chunk (chunk_q),
		.typ   (type_q),
		.bytes (data_q),
		.res   (mres)
	);

	always_comb begin
		commit     = 1'b0;
		fin_status = STAT_DONE;
		fin_rdata  = '0;
		unique case (kind_q)
			KIND_WRITE: begin
				priority if (found_q && same_q) begin
					fin_status = STAT_UNCHANGED;
				end else if (!free_found_q) begin
					fin_status = STAT_FULL;
				end else begin
					fin_status = STAT_DONE;
					commit     = fin_go;
				end
			end
			KIND_READ: begin
				if (found_q) begin
					fin_rdata = rdata_q;
				end else begin
					fin_status = STAT_NOTFOUND;
				end
			end
			default: begin
				fin_status = STAT_DONE;
			end
		endcase
		// a fresh chunk takes a slot; a replaced one gives its old slot back
		free_after = (commit && !found_q) ? free_q - CNT_W'(1) : free_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			issue_q <= 1'b0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= issue_q;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SCAN;
						issue_q <= 1'b1;
					end
				end
				S_SCAN: begin
					if (issue_q && (cnt_q == IDX_W'(SLOTS - 1))) begin
						issue_q <= 1'b0;
					end
					if (last_s1) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request and scan bookkeeping
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (accept) begin
			kind_q       <= s_tuser;
			id_q         <= s_tdata[31:0];
			chunk_q      <= s_tdata[39:32];
			type_q       <= s_tdata[47:40];
			data_q       <= s_tdata[111:48];
			cnt_q        <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			if (issue_q) begin
				cnt_q <= cnt_q + IDX_W'(1);
			end
			if (vld_s1) begin
				// lowest matching slot and lowest free slot win
				if (mres.hit && !found_q) begin
					found_q <= 1'b1;
					same_q  <= mres.same;
					old_q   <= idx_s1;
					rdata_q <= rd_slot.bytes;
				end
				if (!used_q[idx_s1] && !free_found_q) begin
					free_found_q <= 1'b1;
					dst_q        <= idx_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			free_q <= CNT_W'(SLOTS);
		end else begin
			if (vld_s1 && (kind_q == KIND_ERASE) && mres.id_hit) begin
				used_q[idx_s1] <= 1'b0;
				free_q         <= free_q + CNT_W'(1);
			end
			if (commit) begin
				used_q[dst_q] <= 1'b1;
				if (found_q) begin
					used_q[old_q] <= 1'b0;
				end
				free_q <= free_after;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			m_tuser_q <= fin_status;
			m_tdata_q <= {FREE_W'(free_after), fin_rdata};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`PBS_ASSERT(a_free_bound, clk, arst_n, free_q <= CNT_W'(SLOTS))
	`PBS_ASSERT(a_free_count, clk, arst_n, $countones(~used_q) == int'(free_q))
	`PBS_ASSERT_NEXT(a_accept_scan, clk, arst_n, accept, state_q == S_SCAN)
	`PBS_ASSERT_IMPL(a_full_empty, clk, arst_n, m_tvalid && (m_tuser == STAT_FULL),
		m_tdata[71:64] == 8'd0)
endmodule
`default_nettype wire

@@ bench/tb_parameter_block_store_core.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_parameter_block_store_core
	import pbs_pkg::*;
();

	// kind code the block leaves undecoded
	localparam logic [1:0]  KIND_UNUSED = 2'd3;
	localparam int          CYCLE_LIMIT = 700000;
	localparam int          MAX_REPORTS = 10;
	localparam logic [31:0] FILL_ID     = 32'h5A5A_C3C3;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] read_data;
		logic [7:0]  free_slots;
	} store_result_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [111:0] s_tdata;   // param_id, chunk_index, type_code, chunk_data
	logic [1:0]   s_tuser;   // kind
	logic         m_tvalid;
	logic         m_tready;
	logic [71:0]  m_tdata;   // read_data, free_slots
	logic [1:0]   m_tuser;   // status

	parameter_block_store_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow copy of the slot table
	logic        tbl_used  [SLOTS];
	logic [31:0] tbl_id    [SLOTS];
	logic [7:0]  tbl_chunk [SLOTS];
	logic [7:0]  tbl_typ   [SLOTS];
	logic [63:0] tbl_bytes [SLOTS];

	store_result_t expected_results[$];
	store_result_t chk_exp;
	store_result_t chk_got;
	int            mismatch_count = 0;
	int            result_count   = 0;
	int            cycle_count    = 0;
	int            burst_left     = 0;
	int            rx_left        = 0;
	int            rx_mode        = 0;

	function automatic store_result_t store_predict(input logic [1:0] kind,
			input logic [31:0] id, input logic [7:0] chunk, input logic [7:0] typ,
			input logic [63:0] data);
		store_result_t r;
		int hit;
		int dst;
		int nfree;
		r.status    = STAT_DONE;
		r.read_data = '0;
		hit = -1;
		dst = -1;
		nfree = 0;
		for (int i = 0; i < SLOTS; i++) begin
			if (hit < 0 && tbl_used[i] && tbl_id[i] == id && tbl_chunk[i] == chunk)
				hit = i;
		end
		case (kind)
			KIND_WRITE: begin
				if (hit >= 0 && tbl_typ[hit] == typ && tbl_bytes[hit] == data) begin
					r.status = STAT_UNCHANGED;
				end else begin
					for (int i = SLOTS - 1; i >= 0; i--)
						if (!tbl_used[i]) dst = i;
					if (dst < 0) begin
						r.status = STAT_FULL;
					end else begin
						tbl_used[dst]  = 1'b1;
						tbl_id[dst]    = id;
						tbl_chunk[dst] = chunk;
						tbl_typ[dst]   = typ;
						tbl_bytes[dst] = data;
						if (hit >= 0) tbl_used[hit] = 1'b0;
					end
				end
			end
			KIND_READ: begin
				if (hit >= 0) r.read_data = tbl_bytes[hit];
				else r.status = STAT_NOTFOUND;
			end
			KIND_ERASE: begin
				for (int i = 0; i < SLOTS; i++)
					if (tbl_used[i] && tbl_id[i] == id) tbl_used[i] = 1'b0;
			end
			default: ;
		endcase
		for (int i = 0; i < SLOTS; i++)
			if (!tbl_used[i]) nfree++;
		r.free_slots = nfree[7:0];
		return r;
	endfunction

	// sender: bursts of beats separated by random gaps; call at a rising edge
	task automatic send_item(input logic [1:0] kind, input logic [31:0] id,
			input logic [7:0] chunk, input logic [7:0] typ, input logic [63:0] data);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
			                                         : $urandom_range(1, 6);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {data, typ, chunk, id};
		do @(posedge clk); while (!s_tready);
		expected_results.push_back(store_predict(kind, id, chunk, typ, data));
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	task automatic test_directed_cases();
		send_item(KIND_READ,   32'h0000_0000, 8'h00, 8'h00, 64'h0);
		send_item(KIND_WRITE,  32'h0000_0000, 8'h00, 8'h00, 64'h0);
		send_item(KIND_WRITE,  32'h0000_0000, 8'h00, 8'h00, 64'h0);
		// read ignores type and data
		send_item(KIND_READ,   32'h0000_0000, 8'h00, 8'hFF, '1);
		send_item(KIND_WRITE,  32'hFFFF_FFFF, 8'hFF, 8'hFF, '1);
		send_item(KIND_READ,   32'hFFFF_FFFF, 8'hFF, 8'h00, 64'h0);
		// type change alone moves the chunk to a new slot
		send_item(KIND_WRITE,  32'hFFFF_FFFF, 8'hFF, 8'hFE, '1);
		send_item(KIND_WRITE,  32'hFFFF_FFFF, 8'hFF, 8'hFE, 64'hFFFF_FFFF_FFFF_FFFE);
		send_item(KIND_READ,   32'hFFFF_FFFF, 8'hFF, 8'h00, 64'h0);
		// partial key hits
		send_item(KIND_READ,   32'hFFFF_FFFF, 8'hFE, 8'h00, 64'h0);
		send_item(KIND_READ,   32'hFFFF_FFFE, 8'hFF, 8'h00, 64'h0);
		send_item(KIND_ERASE,  32'hFFFF_FFFF, 8'h00, 8'h00, 64'h0);
		send_item(KIND_READ,   32'hFFFF_FFFF, 8'hFF, 8'h00, 64'h0);
		send_item(KIND_ERASE,  32'h1234_5678, 8'hFF, 8'hFF, '1);
		send_item(KIND_UNUSED, 32'hFFFF_FFFF, 8'hFF, 8'hFF, '1);
		send_item(KIND_READ,   32'h0000_0000, 8'h00, 8'h00, 64'h0);
		send_item(KIND_WRITE,  32'h0000_0000, 8'h01, 8'h80, 64'h8000_0000_0000_0001);
		send_item(KIND_WRITE,  32'h0000_0000, 8'h00, 8'h00, 64'h1);
		send_item(KIND_ERASE,  32'h0000_0000, 8'hAA, 8'h55, 64'hDEAD_BEEF_0BAD_F00D);
		send_item(KIND_READ,   32'h0000_0000, 8'h01, 8'h00, 64'h0);
	endtask

	task automatic test_table_full();
		logic [63:0] first_data;
		logic [63:0] fill_data;
		first_data = {$urandom, $urandom};
		for (int i = 0; i < SLOTS; i++) begin
			fill_data = (i == 0) ? first_data : {$urandom, $urandom};
			send_item(KIND_WRITE, FILL_ID, i[7:0], 8'h5A, fill_data);
		end
		send_item(KIND_WRITE, FILL_ID, 8'd64, 8'h5A, 64'h0);
		// rewrite of a stored chunk has no spare slot, old copy must survive
		send_item(KIND_WRITE, FILL_ID, 8'd0, 8'h5A, ~first_data);
		send_item(KIND_READ,  FILL_ID, 8'd0, 8'h00, 64'h0);
		send_item(KIND_WRITE, FILL_ID, 8'd0, 8'h5A, first_data);
		send_item(KIND_ERASE, FILL_ID, 8'd0, 8'h00, 64'h0);
		send_item(KIND_READ,  FILL_ID, 8'd5, 8'h00, 64'h0);
	endtask

	task automatic test_random_mix(input int count);
		logic [31:0] id_pool   [6];
		logic [63:0] data_pool [4];
		logic [1:0]  kind;
		logic [31:0] id;
		logic [7:0]  chunk;
		logic [7:0]  typ;
		logic [63:0] data;
		int          pick;
		for (int k = 0; k < 5; k++) id_pool[k] = $urandom;
		id_pool[5] = 32'hFFFF_FFFF;
		data_pool[0] = 64'h0;
		data_pool[1] = '1;
		data_pool[2] = {$urandom, $urandom};
		data_pool[3] = {$urandom, $urandom};
		for (int n = 0; n < count; n++) begin
			pick  = $urandom_range(0, 99);
			id    = id_pool[$urandom_range(0, 5)];
			chunk = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
			                                    : 8'($urandom_range(0, 11));
			typ   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
			                                    : 8'($urandom_range(0, 1));
			data  = ($urandom_range(0, 1) == 1) ? data_pool[$urandom_range(0, 3)]
			                                    : {$urandom, $urandom};
			if (pick < 58)      kind = KIND_WRITE;
			else if (pick < 88) kind = KIND_READ;
			else if (pick < 93) kind = KIND_ERASE;
			else if (pick < 96) kind = KIND_UNUSED;
			else begin
				kind = 2'($urandom_range(0, 3));
				id   = $urandom;
			end
			send_item(kind, id, chunk, typ, data);
			if (n % 200 == 199) wait_results_drained();
		end
	endtask

	// receiver: ready, stalled or choppy stretches
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_left = (rx_mode == 1) ? $urandom_range(1, 30) : $urandom_range(1, 60);
		end
		rx_left = rx_left - 1;
		case (rx_mode)
			0:       m_tready <= 1'b1;
			1:       m_tready <= 1'b0;
			default: m_tready <= ($urandom_range(0, 1) == 1);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			chk_got.status     = m_tuser;
			chk_got.read_data  = m_tdata[63:0];
			chk_got.free_slots = m_tdata[71:64];
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("ERROR: result beat %0d with none pending: status %0d data %h free %0d",
						result_count, chk_got.status, chk_got.read_data, chk_got.free_slots);
			end else begin
				chk_exp = expected_results.pop_front();
				if (chk_got.status !== chk_exp.status || chk_got.read_data !== chk_exp.read_data
						|| chk_got.free_slots !== chk_exp.free_slots) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("ERROR: result %0d: status %0d/%0d data %h/%h free %0d/%0d (exp/got)",
							result_count, chk_exp.status, chk_got.status, chk_exp.read_data,
							chk_got.read_data, chk_exp.free_slots, chk_got.free_slots);
				end
			end
			result_count++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_parameter_block_store_core: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		for (int i = 0; i < SLOTS; i++) tbl_used[i] = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		wait_results_drained();
		test_table_full();
		wait_results_drained();
		test_random_mix(860);
		wait_results_drained();
		repeat (SLOTS + 16) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("tb_parameter_block_store_core: done, clean");
		end else begin
			$display("tb_parameter_block_store_core: done, errors");
		end
		$finish;
	end
endmodule
`default_nettype wire
